@@ sv/sd_spi_card_init_sequencer_defines.svh @@
// assertion macros for the sd spi card init sequencer
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef SD_SPI_CARD_INIT_SEQUENCER_DEFINES_SVH
`define SD_SPI_CARD_INIT_SEQUENCER_DEFINES_SVH

// same-cycle implication check
`define SDI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define SDI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sdi_pkg.sv @@
// types, codes and the command frame table of the sd spi init sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package sdi_pkg;

  // sequencer phases, one-hot
  typedef enum logic [18:0] {
    PH_IDLE    = 19'h00001,
    PH_DUMMY   = 19'h00002,
    PH_CMD0    = 19'h00004,
    PH_CMD8    = 19'h00008,
    PH_L55     = 19'h00010,
    PH_L41     = 19'h00020,
    PH_CMD1    = 19'h00040,
    PH_CMD59   = 19'h00080,
    PH_CMD16   = 19'h00100,
    PH_H55     = 19'h00200,
    PH_H41     = 19'h00400,
    PH_CMD58   = 19'h00800,
    PH_V1GAP   = 19'h01000,
    PH_FASTGAP = 19'h02000,
    PH_ECHO    = 19'h04000,
    PH_ECHOGAP = 19'h08000,
    PH_OCR     = 19'h10000,
    PH_OCRGAP  = 19'h20000,
    PH_DONE    = 19'h40000
  } phase_e;

  // position inside one command frame, one-hot
  typedef enum logic [3:0] {
    PT_PRE   = 4'b0001,
    PT_FRAME = 4'b0010,
    PT_POLL  = 4'b0100,
    PT_POST  = 4'b1000
  } part_e;

  // configuration register indexes
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 9;
  localparam logic [CFG_IW-1:0] CFG_POLL_LIMIT   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_IDLE_LIMIT   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LEGACY_LIMIT = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_HC_LIMIT     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DUMMY_COUNT  = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_POLL_LIMIT   = 8'd200;
  localparam logic [8:0] RST_IDLE_LIMIT   = 9'd200;
  localparam logic [8:0] RST_LEGACY_LIMIT = 9'd400;
  localparam logic [8:0] RST_HC_LIMIT     = 9'd200;
  localparam logic [3:0] RST_DUMMY_COUNT  = 4'd10;

  // card type codes
  localparam logic [2:0] CARD_UNKNOWN = 3'd0;
  localparam logic [2:0] CARD_MMC     = 3'd1;
  localparam logic [2:0] CARD_SDV1    = 3'd2;
  localparam logic [2:0] CARD_SDV2    = 3'd3;
  localparam logic [2:0] CARD_SDHC    = 3'd4;

  // card response and bus byte codes
  localparam logic [7:0] BYTE_IDLE    = 8'hFF;
  localparam logic [7:0] R1_READY     = 8'h00;
  localparam logic [7:0] R1_IN_IDLE   = 8'h01;
  localparam logic [7:0] R1_ILLEGAL   = 8'h05;
  localparam logic [7:0] ECHO_VOLTAGE = 8'h01;
  localparam logic [7:0] ECHO_PATTERN = 8'hAA;
  localparam logic [7:0] CODE_FAIL    = 8'h01;
  localparam logic [7:0] CODE_OK      = 8'h00;

  // command codes, arguments and crc bytes
  localparam logic [5:0]  CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0]  CMD_SEND_OP   = 6'd1;
  localparam logic [5:0]  CMD_IF_COND   = 6'd8;
  localparam logic [5:0]  CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0]  CMD_APP_OP    = 6'd41;
  localparam logic [5:0]  CMD_APP       = 6'd55;
  localparam logic [5:0]  CMD_READ_OCR  = 6'd58;
  localparam logic [5:0]  CMD_CRC_ON    = 6'd59;
  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [31:0] ARG_BLOCKLEN  = 32'h0000_0200;
  localparam logic [31:0] ARG_HCS       = 32'h4000_0000;
  localparam logic [7:0]  CRC_GO_IDLE   = 8'h95;
  localparam logic [7:0]  CRC_IF_COND   = 8'h87;
  localparam logic [1:0]  CMD_START     = 2'b01;

  // frame length numbers
  localparam logic [2:0] FRAME_LAST     = 3'd5;
  localparam logic [2:0] PRE_BYTES      = 3'd3;
  localparam logic [2:0] PRE_BYTES_HOLD = 3'd1;
  localparam logic [2:0] READ_BYTES     = 3'd4;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [7:0] poll_limit;
    logic [8:0] idle_limit;
    logic [8:0] legacy_limit;
    logic [8:0] hc_limit;
    logic [3:0] dummy_count;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    phase_e     phase;
    part_e      part;
    logic [2:0] frame_index;
    logic [3:0] dummy_count;
    logic [7:0] poll_count;
    logic [8:0] retry_count;
    logic [2:0] card_kind;
    logic [7:0] last_response;
    logic       speed_flag;
  } state_t;

  // trailing byte store, four bytes
  typedef logic [3:0][7:0] trail_t;

  // write into the trailing byte store
  typedef struct packed {
    logic       we;
    logic [1:0] idx;
    logic [7:0] data;
  } trail_wr_t;

  // one result item
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       fast_clock;
    logic       done_res;
    logic [7:0] result_code;
    logic [2:0] card_type;
  } res_t;

  // frames that keep chip select asserted after the response
  function automatic logic cmd_hold(input phase_e ph);
    logic h;
    h = (ph == PH_CMD8) || (ph == PH_CMD58);
    return h;
  endfunction

  // byte idx of the command frame sent in phase ph
  function automatic logic [7:0] frame_byte(input phase_e ph, input logic [2:0] idx);
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    cmd = CMD_GO_IDLE;
    arg = '0;
    crc = '0;
    case (ph)
      PH_CMD0: begin
        cmd = CMD_GO_IDLE;
        crc = CRC_GO_IDLE;
      end
      PH_CMD8: begin
        cmd = CMD_IF_COND;
        arg = ARG_IF_COND;
        crc = CRC_IF_COND;
      end
      PH_L55, PH_H55: cmd = CMD_APP;
      PH_L41: cmd = CMD_APP_OP;
      PH_H41: begin
        cmd = CMD_APP_OP;
        arg = ARG_HCS;
      end
      PH_CMD1: cmd = CMD_SEND_OP;
      PH_CMD59: begin
        cmd = CMD_CRC_ON;
        crc = CRC_GO_IDLE;
      end
      PH_CMD16: begin
        cmd = CMD_BLOCKLEN;
        arg = ARG_BLOCKLEN;
        crc = CRC_GO_IDLE;
      end
      PH_CMD58: cmd = CMD_READ_OCR;
      default: cmd = CMD_GO_IDLE;
    endcase
    case (idx)
      3'd0: b = {CMD_START, cmd};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/sdi_cfg_regs.sv @@
// configuration registers of the sd spi init sequencer, plain write port
// depends on sdi_pkg
`default_nettype none

module sdi_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [sdi_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [sdi_pkg::CFG_DW-1:0] cfg_data_i,
  output sdi_pkg::cfg_t                  cfg_o
);
  import sdi_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POLL_LIMIT:   cfg_d.poll_limit   = cfg_data_i[7:0];
        CFG_IDLE_LIMIT:   cfg_d.idle_limit   = cfg_data_i[8:0];
        CFG_LEGACY_LIMIT: cfg_d.legacy_limit = cfg_data_i[8:0];
        CFG_HC_LIMIT:     cfg_d.hc_limit     = cfg_data_i[8:0];
        CFG_DUMMY_COUNT:  cfg_d.dummy_count  = cfg_data_i[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_limit   <= RST_POLL_LIMIT;
      cfg_q.idle_limit   <= RST_IDLE_LIMIT;
      cfg_q.legacy_limit <= RST_LEGACY_LIMIT;
      cfg_q.hc_limit     <= RST_HC_LIMIT;
      cfg_q.dummy_count  <= RST_DUMMY_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/sdi_step.sv @@
// next-state and result logic of the sd spi init sequencer, one byte per step
// depends on sdi_pkg; purely combinational
`default_nettype none

module sdi_step (
  input  wire sdi_pkg::cfg_t     cfg_i,
  input  wire sdi_pkg::state_t   st_i,
  input  wire sdi_pkg::trail_t   trail_i,
  input  wire logic          start_req_i,
  input  wire logic [7:0]    rx_byte_i,
  output sdi_pkg::state_t    st_o,
  output sdi_pkg::trail_wr_t trail_wr_o,
  output sdi_pkg::res_t      res_o
);
  import sdi_pkg::*;

  state_t     nxt;
  logic [7:0] tx;
  logic       cs;
  logic       hold;
  logic       do_dec;
  logic [7:0] dec_r;
  logic       bc_en;
  phase_e     bc_ph;
  logic       fin_en;
  logic [7:0] fin_code;
  logic [9:0] retry_inc;
  logic [8:0] idle_lim;
  logic [8:0] legacy_lim;
  logic [8:0] hc_lim;
  logic [3:0] dummy_lim;
  logic [2:0] fi_inc;
  logic       read_en;
  phase_e     read_gap;

  // zero limits behave as one
  assign idle_lim   = (cfg_i.idle_limit == '0) ? 9'd1 : cfg_i.idle_limit;
  assign legacy_lim = (cfg_i.legacy_limit == '0) ? 9'd1 : cfg_i.legacy_limit;
  assign hc_lim     = (cfg_i.hc_limit == '0) ? 9'd1 : cfg_i.hc_limit;
  assign dummy_lim  = (cfg_i.dummy_count == '0) ? 4'd1 : cfg_i.dummy_count;

  assign retry_inc = {1'b0, st_i.retry_count} + 10'd1;
  assign fi_inc    = st_i.frame_index + 3'd1;
  assign hold      = cmd_hold(st_i.phase);

  always_comb begin
    nxt        = st_i;
    tx         = BYTE_IDLE;
    cs         = 1'b0;
    do_dec     = 1'b0;
    dec_r      = st_i.last_response;
    bc_en      = 1'b0;
    bc_ph      = PH_CMD0;
    fin_en     = 1'b0;
    fin_code   = CODE_OK;
    read_en    = 1'b0;
    read_gap   = PH_ECHOGAP;
    trail_wr_o = '{we: 1'b0, idx: st_i.frame_index[1:0], data: rx_byte_i};

    if (start_req_i) begin
      // restart from the dummy clocks
      nxt.phase         = PH_DUMMY;
      nxt.part          = PT_PRE;
      nxt.frame_index   = '0;
      nxt.poll_count    = '0;
      nxt.retry_count   = '0;
      nxt.card_kind     = CARD_UNKNOWN;
      nxt.speed_flag    = 1'b0;
      nxt.last_response = BYTE_IDLE;
      nxt.dummy_count   = 4'd1;
    end else begin
      case (st_i.phase)
        // command frame: preamble, six bytes, response poll, release byte unless cs is held
        PH_CMD0, PH_CMD8, PH_L55, PH_L41, PH_CMD1, PH_CMD59, PH_CMD16,
        PH_H55, PH_H41, PH_CMD58: begin
          case (st_i.part)
            PT_PRE: begin
              if (st_i.frame_index < (hold ? PRE_BYTES_HOLD : PRE_BYTES)) begin
                nxt.frame_index = fi_inc;
              end else begin
                nxt.part        = PT_FRAME;
                nxt.frame_index = '0;
                tx              = frame_byte(st_i.phase, 3'd0);
                cs              = 1'b1;
              end
            end
            PT_FRAME: begin
              cs = 1'b1;
              if (st_i.frame_index < FRAME_LAST) begin
                nxt.frame_index = fi_inc;
                tx              = frame_byte(st_i.phase, fi_inc);
              end else begin
                nxt.part       = PT_POLL;
                nxt.poll_count = '0;
              end
            end
            PT_POLL: begin
              if (rx_byte_i == BYTE_IDLE && st_i.poll_count < cfg_i.poll_limit) begin
                nxt.poll_count = st_i.poll_count + 8'd1;
                cs             = 1'b1;
              end else begin
                nxt.last_response = rx_byte_i;
                if (hold) begin
                  do_dec = 1'b1;
                  dec_r  = rx_byte_i;
                end else begin
                  nxt.part = PT_POST;
                end
              end
            end
            default: do_dec = 1'b1;
          endcase
        end
        PH_DUMMY: begin
          if (st_i.dummy_count < dummy_lim) begin
            nxt.dummy_count = st_i.dummy_count + 4'd1;
          end else begin
            nxt.retry_count = '0;
            bc_en           = 1'b1;
            bc_ph           = PH_CMD0;
          end
        end
        PH_V1GAP: begin
          nxt.retry_count = '0;
          bc_en           = 1'b1;
          bc_ph           = PH_L55;
        end
        PH_FASTGAP: begin
          bc_en = 1'b1;
          bc_ph = PH_CMD59;
        end
        PH_ECHO: begin
          read_en  = 1'b1;
          read_gap = PH_ECHOGAP;
        end
        PH_ECHOGAP: begin
          if (trail_i[2] == ECHO_VOLTAGE && trail_i[3] == ECHO_PATTERN) begin
            nxt.retry_count = '0;
            bc_en           = 1'b1;
            bc_ph           = PH_H55;
          end else begin
            fin_en   = 1'b1;
            fin_code = st_i.last_response;
          end
        end
        PH_OCR: begin
          read_en  = 1'b1;
          read_gap = PH_OCRGAP;
        end
        PH_OCRGAP: begin
          nxt.card_kind  = trail_i[0][6] ? CARD_SDHC : CARD_SDV2;
          nxt.speed_flag = 1'b1;
          fin_en         = 1'b1;
          fin_code       = CODE_OK;
        end
        PH_DONE: nxt.phase = PH_DONE;
        default: nxt.phase = PH_IDLE;
      endcase
    end

    // trailing byte read after cmd8 or cmd58
    if (read_en) begin
      trail_wr_o.we   = 1'b1;
      nxt.frame_index = fi_inc;
      if (fi_inc < READ_BYTES) begin
        cs = 1'b1;
      end else begin
        nxt.phase = read_gap;
      end
    end

    // response decision at the end of a frame
    if (do_dec) begin
      case (st_i.phase)
        PH_CMD0: begin
          nxt.retry_count = retry_inc[8:0];
          if (dec_r == R1_IN_IDLE) begin
            bc_en = 1'b1;
            bc_ph = PH_CMD8;
          end else if (retry_inc >= {1'b0, idle_lim}) begin
            fin_en   = 1'b1;
            fin_code = CODE_FAIL;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_CMD0;
          end
        end
        PH_CMD8: begin
          if (dec_r == R1_ILLEGAL) begin
            nxt.card_kind = CARD_SDV1;
            nxt.phase     = PH_V1GAP;
          end else if (dec_r == R1_IN_IDLE) begin
            nxt.phase       = PH_ECHO;
            nxt.frame_index = '0;
            cs              = 1'b1;
          end else begin
            fin_en   = 1'b1;
            fin_code = dec_r;
          end
        end
        PH_L55: begin
          if (dec_r == BYTE_IDLE) begin
            fin_en   = 1'b1;
            fin_code = dec_r;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_L41;
          end
        end
        PH_L41: begin
          nxt.retry_count = retry_inc[8:0];
          if (dec_r == R1_READY) begin
            nxt.speed_flag = 1'b1;
            nxt.phase      = PH_FASTGAP;
          end else if (retry_inc >= {1'b0, legacy_lim}) begin
            nxt.retry_count = '0;
            bc_en           = 1'b1;
            bc_ph           = PH_CMD1;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_L55;
          end
        end
        PH_CMD1: begin
          nxt.retry_count = retry_inc[8:0];
          if (dec_r == R1_READY) begin
            nxt.card_kind  = CARD_MMC;
            nxt.speed_flag = 1'b1;
            nxt.phase      = PH_FASTGAP;
          end else if (retry_inc >= {1'b0, legacy_lim}) begin
            fin_en   = 1'b1;
            fin_code = CODE_FAIL;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_CMD1;
          end
        end
        PH_CMD59: begin
          if (dec_r != R1_READY) begin
            fin_en   = 1'b1;
            fin_code = dec_r;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_CMD16;
          end
        end
        PH_CMD16: begin
          fin_en   = 1'b1;
          fin_code = dec_r;
        end
        PH_H55: begin
          if (dec_r != R1_IN_IDLE) begin
            fin_en   = 1'b1;
            fin_code = dec_r;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_H41;
          end
        end
        PH_H41: begin
          nxt.retry_count = retry_inc[8:0];
          if (dec_r == R1_READY) begin
            bc_en = 1'b1;
            bc_ph = PH_CMD58;
          end else if (retry_inc >= {1'b0, hc_lim}) begin
            fin_en   = 1'b1;
            fin_code = dec_r;
          end else begin
            bc_en = 1'b1;
            bc_ph = PH_H55;
          end
        end
        PH_CMD58: begin
          if (dec_r != R1_READY) begin
            fin_en   = 1'b1;
            fin_code = dec_r;
          end else begin
            nxt.phase       = PH_OCR;
            nxt.frame_index = '0;
            cs              = 1'b1;
          end
        end
        default: nxt.phase = st_i.phase;
      endcase
    end

    // enter a new command frame
    if (bc_en) begin
      nxt.phase       = bc_ph;
      nxt.part        = PT_PRE;
      nxt.frame_index = 3'd1;
      tx              = BYTE_IDLE;
      cs              = 1'b0;
    end

    // finish with a result code
    if (fin_en) begin
      nxt.last_response = fin_code;
      nxt.phase         = PH_DONE;
      tx                = BYTE_IDLE;
      cs                = 1'b0;
    end
  end

  // result item from the updated state
  always_comb begin
    res_o.tx_byte     = tx;
    res_o.cs_active   = cs;
    res_o.fast_clock  = nxt.speed_flag;
    res_o.done_res    = (nxt.phase == PH_DONE);
    res_o.result_code = (nxt.phase == PH_DONE) ? nxt.last_response : CODE_OK;
    res_o.card_type   = nxt.card_kind;
  end

  assign st_o = nxt;

endmodule

`default_nettype wire

@@ sv/sd_spi_card_init_sequencer.sv @@
// sd card spi-mode start-up sequencer, top level
// depends on sdi_pkg, sdi_cfg_regs, sdi_step and the assertion macro header
//
// Usage: every input item is one spi byte exchange. start_req_i = 1 (re)starts the
// sequence and rx_byte_i is ignored; otherwise rx_byte_i is the byte the card
// returned during the exchange of the previous result item. Each result item
// names the next byte to shift out (tx_byte_o), the chip-select level for it
// (cs_active_o), the clock-speed flag, and once the sequence has finished
// done_res_o = 1 with result_code_o and card_type_o.
// Both channels use valid/ready. An item is taken into an input register; the
// sequencer step runs once that item waits and the result slot is free, and writes
// the result register. One item per cycle is sustained while the receiver keeps
// out_ready_i high; the limit is the state update of the sequencer, one step per item.
// When the receiver stalls, the result register holds and the input register
// holds one more item; in_ready_o drops only when both are full.
// Reset empties both registers, loads the configuration defaults and puts the
// sequencer in idle, where it answers 0xFF with chip select released.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i.
`default_nettype none

module sd_spi_card_init_sequencer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [sdi_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [sdi_pkg::CFG_DW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       start_req_i,
  input  wire logic [7:0]                 rx_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [7:0]                      tx_byte_o,
  output logic                            cs_active_o,
  output logic                            fast_clock_o,
  output logic                            done_res_o,
  output logic [7:0]                      result_code_o,
  output logic [2:0]                      card_type_o
);
  import sdi_pkg::*;

`include "sd_spi_card_init_sequencer_defines.svh"

  cfg_t      cfg;
  state_t    st_q, st_d;
  trail_t    trail_q;
  trail_wr_t trail_wr;
  res_t      res_d, res_q;

  logic       in_valid_q;
  logic       in_start_q;
  logic [7:0] in_rx_q;
  logic       out_valid_q;
  logic       fire;
  logic       in_take;

  // configuration registers
  sdi_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake: step fires when an item waits and the result slot frees up
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_start_q <= start_req_i;
      in_rx_q    <= rx_byte_i;
    end
  end

  // sequencer step
  sdi_step u_step (
    .cfg_i       (cfg),
    .st_i        (st_q),
    .trail_i     (trail_q),
    .start_req_i (in_start_q),
    .rx_byte_i   (in_rx_q),
    .st_o        (st_d),
    .trail_wr_o  (trail_wr),
    .res_o       (res_d)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase         <= PH_IDLE;
      st_q.part          <= PT_PRE;
      st_q.frame_index   <= '0;
      st_q.dummy_count   <= '0;
      st_q.poll_count    <= '0;
      st_q.retry_count   <= '0;
      st_q.card_kind     <= CARD_UNKNOWN;
      st_q.last_response <= BYTE_IDLE;
      st_q.speed_flag    <= 1'b0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // trailing byte store, written before it is read
  always_ff @(posedge clk_i) begin
    if (fire && trail_wr.we) begin
      trail_q[trail_wr.idx] <= trail_wr.data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_byte_o     = res_q.tx_byte;
  assign cs_active_o   = res_q.cs_active;
  assign fast_clock_o  = res_q.fast_clock;
  assign done_res_o    = res_q.done_res;
  assign result_code_o = res_q.result_code;
  assign card_type_o   = res_q.card_type;

  // checks
  `SDI_ASSERT_NXT(a_fire_fills_out, clk_i, rst_ni, fire, out_valid_q, "step result lost")
  `SDI_ASSERT_NXT(a_in_holds, clk_i, rst_ni, in_valid_q && !fire, in_valid_q && $stable(in_rx_q) && $stable(in_start_q), "pending item changed")
  `SDI_ASSERT_IMP(a_fast_has_kind, clk_i, rst_ni, st_q.speed_flag, st_q.card_kind != CARD_UNKNOWN, "fast clock without card type")

endmodule

`default_nettype wire

@@ tb/sd_spi_card_init_sequencer_tb.sv @@
// self-checking testbench for the sd card spi start-up sequencer
// depends on sdi_pkg and sd_spi_card_init_sequencer; a card model shapes the rx bytes
`timescale 1ns / 100ps

module sd_spi_card_init_sequencer_tb;
  import sdi_pkg::*;

  localparam int QUIET_LIMIT = 500;

  // one exchange toward the block: restart flag and byte returned by the card
  typedef struct packed {
    logic       start;
    logic [7:0] rx;
  } card_item_t;

  // sequencer view kept by the testbench, plus the byte chosen for the next exchange
  typedef struct packed {
    phase_e          phase;
    part_e           part;
    logic [2:0]      idx;
    logic [3:0]      dummies;
    logic [7:0]      polls;
    logic [8:0]      tries;
    logic [3:0][7:0] trail;
    logic [2:0]      kind;
    logic [7:0]      last_r1;
    logic            fast;
    logic [7:0]      tx;
    logic            cs;
  } card_seq_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_IW-1:0]   cfg_index_i = '0;
  logic [CFG_DW-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                start_req_i = 1'b0;
  logic [7:0]          rx_byte_i   = 8'h00;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [7:0]          tx_byte_o;
  logic                cs_active_o;
  logic                fast_clock_o;
  logic                done_res_o;
  logic [7:0]          result_code_o;
  logic [2:0]          card_type_o;

  card_item_t card_bytes_q[$];
  res_t       next_exchange_q[$];
  card_seq_t  card_view;
  card_seq_t  host_view;
  cfg_t       cfg_model;
  bit         silent;
  bit         host_done;
  int         send_hold, send_burst, recv_hold, recv_burst;
  int         quiet_cycles;
  int         mismatches, items_taken, results_seen, seq_ok, seq_failed;
  int         kinds_seen[8];

  sd_spi_card_init_sequencer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_byte_o    (tx_byte_o),
    .cs_active_o  (cs_active_o),
    .fast_clock_o (fast_clock_o),
    .done_res_o   (done_res_o),
    .result_code_o(result_code_o),
    .card_type_o  (card_type_o)
  );

  always #5 clk_i = ~clk_i;

  // sequencer view right after reset
  function automatic card_seq_t seq_reset();
    card_seq_t s;
    s = '0;
    s.phase   = PH_IDLE;
    s.part    = PT_PRE;
    s.last_r1 = BYTE_IDLE;
    s.tx      = BYTE_IDLE;
    return s;
  endfunction

  function automatic bit is_cmd_phase(input phase_e ph);
    return ph == PH_CMD0 || ph == PH_CMD8 || ph == PH_L55 || ph == PH_L41 ||
           ph == PH_CMD1 || ph == PH_CMD59 || ph == PH_CMD16 || ph == PH_H55 ||
           ph == PH_H41 || ph == PH_CMD58;
  endfunction

  // a limit of zero behaves as one
  function automatic logic [8:0] floor_one(input logic [8:0] v);
    return (v == 9'd0) ? 9'd1 : v;
  endfunction

  // byte n of the six byte command frame sent in a phase
  function automatic logic [7:0] frame_byte_of(input phase_e ph, input logic [2:0] n);
    logic [5:0]  op;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [47:0] frame;
    op  = CMD_GO_IDLE;
    arg = 32'h0;
    crc = 8'h00;
    case (ph)
      PH_CMD0:        crc = CRC_GO_IDLE;
      PH_CMD8: begin
        op  = CMD_IF_COND;
        arg = ARG_IF_COND;
        crc = CRC_IF_COND;
      end
      PH_L55, PH_H55: op = CMD_APP;
      PH_L41:         op = CMD_APP_OP;
      PH_H41: begin
        op  = CMD_APP_OP;
        arg = ARG_HCS;
      end
      PH_CMD1:        op = CMD_SEND_OP;
      PH_CMD59: begin
        op  = CMD_CRC_ON;
        crc = CRC_GO_IDLE;
      end
      PH_CMD16: begin
        op  = CMD_BLOCKLEN;
        arg = ARG_BLOCKLEN;
        crc = CRC_GO_IDLE;
      end
      PH_CMD58:       op = CMD_READ_OCR;
      default:        op = CMD_GO_IDLE;
    endcase
    frame = {CMD_START, op, arg, crc};
    return frame[8 * (5 - n) +: 8];
  endfunction

  // start a command: release bytes come first
  function automatic void open_cmd(inout card_seq_t s, input phase_e ph);
    s.phase = ph;
    s.part  = PT_PRE;
    s.idx   = 3'd1;
  endfunction

  function automatic void close_seq(inout card_seq_t s, input logic [7:0] code);
    s.last_r1 = code;
    s.phase   = PH_DONE;
  endfunction

  // store one trailing byte of an r7 or ocr response
  function automatic void read_trail(inout card_seq_t s, input logic [7:0] rx,
                                     input phase_e gap);
    s.trail[s.idx[1:0]] = rx;
    s.idx = s.idx + 3'd1;
    if (s.idx < READ_BYTES) begin
      s.cs = 1'b1;
    end else begin
      s.phase = gap;
    end
  endfunction

  // next step of the sequence once a command response is known
  function automatic void act_on_r1(inout card_seq_t s, input cfg_t c, input logic [7:0] r);
    case (s.phase)
      PH_CMD0: begin
        s.tries = s.tries + 9'd1;
        if (r == R1_IN_IDLE) open_cmd(s, PH_CMD8);
        else if (s.tries >= floor_one(c.idle_limit)) close_seq(s, CODE_FAIL);
        else open_cmd(s, PH_CMD0);
      end
      PH_CMD8: begin
        if (r == R1_ILLEGAL) begin
          s.kind  = CARD_SDV1;
          s.phase = PH_V1GAP;
        end else if (r == R1_IN_IDLE) begin
          s.phase = PH_ECHO;
          s.idx   = 3'd0;
          s.cs    = 1'b1;
        end else begin
          close_seq(s, r);
        end
      end
      PH_L55: begin
        if (r == BYTE_IDLE) close_seq(s, r);
        else open_cmd(s, PH_L41);
      end
      PH_L41: begin
        s.tries = s.tries + 9'd1;
        if (r == R1_READY) begin
          s.fast  = 1'b1;
          s.phase = PH_FASTGAP;
        end else if (s.tries >= floor_one(c.legacy_limit)) begin
          s.tries = 9'd0;
          open_cmd(s, PH_CMD1);
        end else begin
          open_cmd(s, PH_L55);
        end
      end
      PH_CMD1: begin
        s.tries = s.tries + 9'd1;
        if (r == R1_READY) begin
          s.kind  = CARD_MMC;
          s.fast  = 1'b1;
          s.phase = PH_FASTGAP;
        end else if (s.tries >= floor_one(c.legacy_limit)) begin
          close_seq(s, CODE_FAIL);
        end else begin
          open_cmd(s, PH_CMD1);
        end
      end
      PH_CMD59: begin
        if (r != R1_READY) close_seq(s, r);
        else open_cmd(s, PH_CMD16);
      end
      PH_CMD16: close_seq(s, r);
      PH_H55: begin
        if (r != R1_IN_IDLE) close_seq(s, r);
        else open_cmd(s, PH_H41);
      end
      PH_H41: begin
        s.tries = s.tries + 9'd1;
        if (r == R1_READY) open_cmd(s, PH_CMD58);
        else if (s.tries >= floor_one(c.hc_limit)) close_seq(s, r);
        else open_cmd(s, PH_H55);
      end
      default: begin
        // ocr read follows with chip select still asserted
        if (r != R1_READY) begin
          close_seq(s, r);
        end else begin
          s.phase = PH_OCR;
          s.idx   = 3'd0;
          s.cs    = 1'b1;
        end
      end
    endcase
  endfunction

  // advance the sequencer by one exchange and form the result item
  function automatic res_t seq_advance(inout card_seq_t s, input cfg_t c,
                                       input card_item_t it);
    res_t r;
    logic keep_cs;
    keep_cs = (s.phase == PH_CMD8) || (s.phase == PH_CMD58);
    s.tx = BYTE_IDLE;
    s.cs = 1'b0;
    if (it.start) begin
      s.phase   = PH_DUMMY;
      s.part    = PT_PRE;
      s.idx     = 3'd0;
      s.polls   = 8'd0;
      s.tries   = 9'd0;
      s.kind    = CARD_UNKNOWN;
      s.fast    = 1'b0;
      s.last_r1 = BYTE_IDLE;
      s.dummies = 4'd1;
    end else if (is_cmd_phase(s.phase)) begin
      case (s.part)
        PT_PRE: begin
          if (s.idx < (keep_cs ? PRE_BYTES_HOLD : PRE_BYTES)) begin
            s.idx = s.idx + 3'd1;
          end else begin
            s.part = PT_FRAME;
            s.idx  = 3'd0;
            s.tx   = frame_byte_of(s.phase, 3'd0);
            s.cs   = 1'b1;
          end
        end
        PT_FRAME: begin
          s.cs = 1'b1;
          if (s.idx < FRAME_LAST) begin
            s.idx = s.idx + 3'd1;
            s.tx  = frame_byte_of(s.phase, s.idx);
          end else begin
            s.part  = PT_POLL;
            s.polls = 8'd0;
          end
        end
        PT_POLL: begin
          if (it.rx == BYTE_IDLE && s.polls < c.poll_limit) begin
            s.polls = s.polls + 8'd1;
            s.cs    = 1'b1;
          end else begin
            // a poll timeout leaves 0xff as the response
            s.last_r1 = it.rx;
            if (keep_cs) act_on_r1(s, c, it.rx);
            else s.part = PT_POST;
          end
        end
        default: act_on_r1(s, c, s.last_r1);
      endcase
    end else begin
      case (s.phase)
        PH_DUMMY: begin
          if ({5'd0, s.dummies} < floor_one({5'd0, c.dummy_count})) begin
            s.dummies = s.dummies + 4'd1;
          end else begin
            s.tries = 9'd0;
            open_cmd(s, PH_CMD0);
          end
        end
        PH_V1GAP: begin
          s.tries = 9'd0;
          open_cmd(s, PH_L55);
        end
        PH_FASTGAP: open_cmd(s, PH_CMD59);
        PH_ECHO:    read_trail(s, it.rx, PH_ECHOGAP);
        PH_ECHOGAP: begin
          if (s.trail[2] == ECHO_VOLTAGE && s.trail[3] == ECHO_PATTERN) begin
            s.tries = 9'd0;
            open_cmd(s, PH_H55);
          end else begin
            close_seq(s, s.last_r1);
          end
        end
        PH_OCR:     read_trail(s, it.rx, PH_OCRGAP);
        PH_OCRGAP: begin
          s.kind = s.trail[0][6] ? CARD_SDHC : CARD_SDV2;
          s.fast = 1'b1;
          close_seq(s, CODE_OK);
        end
        PH_DONE:    s.phase = PH_DONE;
        default:    s.phase = PH_IDLE;
      endcase
    end
    r.tx_byte     = s.tx;
    r.cs_active   = s.cs;
    r.fast_clock  = s.fast;
    r.done_res    = (s.phase == PH_DONE);
    r.result_code = r.done_res ? s.last_r1 : 8'h00;
    r.card_type   = s.kind;
    return r;
  endfunction

  // card behavior: answers shaped by what the sequencer is waiting for
  function automatic logic [7:0] card_reply(input card_seq_t s, input bit mute);
    int unsigned roll;
    logic [7:0]  noise;
    logic [7:0]  reply;
    roll  = $urandom_range(0, 99);
    noise = 8'($urandom_range(0, 255));
    reply = noise;
    if (s.phase == PH_ECHO) begin
      if (s.idx == 3'd2 && roll < 90) reply = ECHO_VOLTAGE;
      if (s.idx == 3'd3 && roll < 90) reply = ECHO_PATTERN;
    end else if (is_cmd_phase(s.phase) && s.part == PT_POLL) begin
      if (mute || roll < 25) begin
        reply = BYTE_IDLE;
      end else begin
        roll = $urandom_range(0, 99);
        case (s.phase)
          PH_CMD0:                 reply = (roll < 75) ? R1_IN_IDLE : noise;
          PH_CMD8:                 reply = (roll < 50) ? R1_IN_IDLE :
                                           (roll < 85) ? R1_ILLEGAL : noise;
          PH_L41, PH_CMD1, PH_H41: reply = (roll < 45) ? R1_READY :
                                           (roll < 90) ? R1_IN_IDLE : noise;
          PH_L55, PH_H55:          reply = (roll < 85) ? R1_IN_IDLE : noise;
          default:                 reply = (roll < 85) ? R1_READY : noise;
        endcase
      end
    end
    return reply;
  endfunction

  // wait before the next item or result, with stretches of no waiting
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst = burst - 1;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      burst = int'($urandom_range(8, 40));
      return 0;
    end
    return int'($urandom_range(0, 10));
  endfunction

  // queue one item and follow it in the card-side view
  task automatic push_exchange(input logic st, input logic [7:0] rx);
    card_item_t it;
    part_e      was;
    it.start = st;
    it.rx    = rx;
    card_bytes_q.push_back(it);
    was = card_view.part;
    void'(seq_advance(card_view, cfg_model, it));
    // now and then a card that stays silent through a whole poll window
    if (was == PT_FRAME && card_view.part == PT_POLL)
      silent = (cfg_model.poll_limit <= 8'd6) && ($urandom_range(0, 7) == 0);
  endtask

  // random card traffic; items ignored while idle or finished are not counted
  task automatic run_card(input int n);
    int  taken;
    bit  st;
    taken = 0;
    while (taken < n) begin
      if (card_view.phase == PH_IDLE || card_view.phase == PH_DONE)
        st = ($urandom_range(0, 3) == 0);
      else
        st = ($urandom_range(0, 149) == 0);
      if (st || (card_view.phase != PH_IDLE && card_view.phase != PH_DONE))
        taken++;
      push_exchange(st, st ? 8'($urandom_range(0, 255)) : card_reply(card_view, silent));
    end
  endtask

  // sender holds off until every queued item is through and answered
  task automatic drain_exchanges();
    while (card_bytes_q.size() != 0 || in_valid_i || next_exchange_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [8:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_POLL_LIMIT:   cfg_model.poll_limit   = data[7:0];
      CFG_IDLE_LIMIT:   cfg_model.idle_limit   = data;
      CFG_LEGACY_LIMIT: cfg_model.legacy_limit = data;
      CFG_HC_LIMIT:     cfg_model.hc_limit     = data;
      CFG_DUMMY_COUNT:  cfg_model.dummy_count  = data[3:0];
      default:          cfg_model = cfg_model;
    endcase
  endtask

  task automatic set_limits(input logic [8:0] poll, input logic [8:0] idle,
                            input logic [8:0] legacy, input logic [8:0] hc,
                            input logic [8:0] dummy);
    write_reg(CFG_POLL_LIMIT, poll);
    write_reg(CFG_IDLE_LIMIT, idle);
    write_reg(CFG_LEGACY_LIMIT, legacy);
    write_reg(CFG_HC_LIMIT, hc);
    write_reg(CFG_DUMMY_COUNT, dummy);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      mismatches++;
    end
  endtask

  // driver: predicts on every accepted item, then presents the next one
  always @(posedge clk_i) begin : drive_items
    card_item_t sent;
    card_item_t nxt;
    res_t       want;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sent.start = start_req_i;
        sent.rx    = rx_byte_i;
        want = seq_advance(host_view, cfg_model, sent);
        next_exchange_q.push_back(want);
        items_taken++;
        if (want.done_res && !host_done) begin
          kinds_seen[want.card_type]++;
          if (want.result_code == CODE_OK) seq_ok++;
          else seq_failed++;
        end
        host_done = want.done_res;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid_i <= 1'b0;
        end else if (card_bytes_q.size() != 0) begin
          nxt = card_bytes_q.pop_front();
          start_req_i <= nxt.start;
          rx_byte_i   <= nxt.rx;
          in_valid_i  <= 1'b1;
          send_hold = draw_wait(send_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (next_exchange_q.size() == 0) begin
          $error("result item with none expected, tx_byte %02h", tx_byte_o);
          mismatches++;
        end else begin
          want = next_exchange_q.pop_front();
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("cs_active", 8'(want.cs_active), 8'(cs_active_o));
          check_field("fast_clock", 8'(want.fast_clock), 8'(fast_clock_o));
          check_field("done_res", 8'(want.done_res), 8'(done_res_o));
          check_field("result_code", want.result_code, result_code_o);
          check_field("card_type", 8'(want.card_type), 8'(card_type_o));
        end
        results_seen++;
        recv_hold = draw_wait(recv_burst);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_ready_i <= (recv_hold == 0);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus: directed start-up, then card traffic under several register settings
  initial begin
    card_view = seq_reset();
    host_view = seq_reset();
    cfg_model = {RST_POLL_LIMIT, RST_IDLE_LIMIT, RST_LEGACY_LIMIT, RST_HC_LIMIT,
                 RST_DUMMY_COUNT};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // never started: idle answers whatever arrives
    push_exchange(1'b0, 8'h00);
    push_exchange(1'b0, 8'hFF);
    push_exchange(1'b0, 8'h5A);
    push_exchange(1'b0, 8'hA5);
    // start, then restart during the dummy bytes
    push_exchange(1'b1, 8'h3C);
    push_exchange(1'b0, 8'h77);
    push_exchange(1'b0, 8'h88);
    push_exchange(1'b1, 8'hC3);
    run_card(150);

    // zero limits, lowest, highest, tight and random settings
    drain_exchanges();
    set_limits(9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
    run_card(100);
    drain_exchanges();
    set_limits(9'd255, 9'd511, 9'd511, 9'd511, 9'd15);
    run_card(100);
    drain_exchanges();
    set_limits(9'd1, 9'd1, 9'd1, 9'd1, 9'd1);
    run_card(100);
    drain_exchanges();
    set_limits(9'd2, 9'd3, 9'd2, 9'd3, 9'd2);
    run_card(150);
    drain_exchanges();
    set_limits(9'($urandom_range(0, 8)), 9'($urandom_range(1, 6)),
               9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)),
               9'($urandom_range(1, 15)));
    run_card(150);

    drain_exchanges();
    repeat (20) @(posedge clk_i);
    $display("checked %0d results for %0d items over six register settings",
             results_seen, items_taken);
    $display("sequences ended ok %0d, failed %0d; mmc %0d, v1 %0d, v2 %0d, sdhc %0d",
             seq_ok, seq_failed, kinds_seen[CARD_MMC], kinds_seen[CARD_SDV1],
             kinds_seen[CARD_SDV2], kinds_seen[CARD_SDHC]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
